>>> src/bencoded_token_stream_parser_unit_macros.svh
// Assertion macros for the checker file of the bencode tokenizer.
// Depends on nothing; pulled in by `include.
`ifndef BENCODED_TOKEN_STREAM_PARSER_UNIT_MACROS_SVH
`define BENCODED_TOKEN_STREAM_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BTSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("btsp: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BTSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("btsp: next-cycle check failed");

`endif

>>> src/btsp_pkg.sv
// Shared types and constants of the bencode tokenizer.
// Depends on nothing; used by btsp_step and the top level.
`default_nettype none

package btsp_pkg;

    localparam int MAX_FIELD_CHARS = 63;
    localparam int LEN_BITS        = 32;
    localparam int FIELD_W         = $clog2(MAX_FIELD_CHARS + 1);

    // token kinds
    localparam logic [2:0] KIND_INT     = 3'd0;
    localparam logic [2:0] KIND_BYTES   = 3'd1;
    localparam logic [2:0] KIND_LIST    = 3'd2;
    localparam logic [2:0] KIND_DICT    = 3'd3;
    localparam logic [2:0] KIND_END     = 3'd4;
    localparam logic [2:0] KIND_INVALID = 3'd5;

    // parser modes
    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_INT     = 3'd1;
    localparam logic [2:0] MODE_LEN     = 3'd2;
    localparam logic [2:0] MODE_PAYLOAD = 3'd3;
    localparam logic [2:0] MODE_ERROR   = 3'd4;

    // characters
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [2:0]          mode;
        logic [FIELD_W-1:0]  field_chars;
        logic [LEN_BITS-1:0] len;
        logic                digits_done;
    } t_state;

    typedef struct packed {
        logic       valid;
        logic [2:0] kind;
        logic [7:0] data;
        logic       has_data;
        logic       last;
    } t_result;

endpackage

`default_nettype wire

>>> src/btsp_step.sv
// Next-state and result logic for one input byte of the bencode tokenizer.
// Depends on btsp_pkg.
`default_nettype none

module btsp_step (
    input  wire logic [7:0]       i_byte,
    input  wire btsp_pkg::t_state i_cur,
    output btsp_pkg::t_state      o_nxt,
    output btsp_pkg::t_result     o_res
);
    import btsp_pkg::*;

    logic                digit;
    logic [3:0]          dval;
    logic [LEN_BITS+3:0] len_x10;
    logic                len_ovf;
    logic                field_full;

    assign digit      = i_byte inside {[CH_ZERO:CH_NINE]};
    assign dval       = 4'(i_byte - CH_ZERO);
    // len*10 + d as shift-add; the top four bits flag overflow
    assign len_x10    = {1'b0, i_cur.len, 3'b000} + {3'b000, i_cur.len, 1'b0}
                      + {(LEN_BITS)'(0), dval};
    assign len_ovf    = |len_x10[LEN_BITS+3:LEN_BITS];
    assign field_full = (i_cur.field_chars == FIELD_W'(MAX_FIELD_CHARS));

    always_comb begin
        o_nxt = i_cur;
        o_res = '0;
        case (i_cur.mode)
            MODE_IDLE: begin
                if (i_byte == CH_L) begin
                    o_res = '{1'b1, KIND_LIST, 8'd0, 1'b0, 1'b1};
                end else if (i_byte == CH_D) begin
                    o_res = '{1'b1, KIND_DICT, 8'd0, 1'b0, 1'b1};
                end else if (i_byte == CH_E) begin
                    o_res = '{1'b1, KIND_END, 8'd0, 1'b0, 1'b1};
                end else if (i_byte == CH_I) begin
                    o_nxt.mode        = MODE_INT;
                    o_nxt.field_chars = '0;
                end else if (digit) begin
                    o_nxt.mode        = MODE_LEN;
                    o_nxt.field_chars = FIELD_W'(1);
                    o_nxt.len         = LEN_BITS'(dval);
                    o_nxt.digits_done = 1'b0;
                end else begin
                    o_nxt.mode = MODE_ERROR;
                    o_res      = '{1'b1, KIND_INVALID, 8'd0, 1'b0, 1'b1};
                end
            end
            MODE_INT: begin
                if (i_byte == CH_E) begin
                    o_nxt.mode = MODE_IDLE;
                    o_res      = '{1'b1, KIND_INT, 8'd0, 1'b0, 1'b1};
                end else if (field_full) begin
                    o_nxt.mode = MODE_ERROR;
                    o_res      = '{1'b1, KIND_INVALID, 8'd0, 1'b0, 1'b1};
                end else begin
                    o_nxt.field_chars = i_cur.field_chars + FIELD_W'(1);
                    o_res             = '{1'b1, KIND_INT, i_byte, 1'b1, 1'b0};
                end
            end
            MODE_LEN: begin
                if (i_byte == CH_COLON) begin
                    if (i_cur.len == '0) begin
                        o_nxt.mode = MODE_IDLE;
                        o_res      = '{1'b1, KIND_BYTES, 8'd0, 1'b0, 1'b1};
                    end else begin
                        o_nxt.mode = MODE_PAYLOAD;
                    end
                end else if (field_full) begin
                    o_nxt.mode = MODE_ERROR;
                    o_res      = '{1'b1, KIND_INVALID, 8'd0, 1'b0, 1'b1};
                end else begin
                    o_nxt.field_chars = i_cur.field_chars + FIELD_W'(1);
                    if (!i_cur.digits_done) begin
                        if (digit) begin
                            if (len_ovf) begin
                                o_nxt.mode = MODE_ERROR;
                                o_res      = '{1'b1, KIND_INVALID, 8'd0, 1'b0, 1'b1};
                            end else begin
                                o_nxt.len = len_x10[LEN_BITS-1:0];
                            end
                        end else begin
                            o_nxt.digits_done = 1'b1;
                        end
                    end
                end
            end
            MODE_PAYLOAD: begin
                // len is at least one here
                o_nxt.len = i_cur.len - LEN_BITS'(1);
                if (i_cur.len <= LEN_BITS'(1)) begin
                    o_nxt.mode = MODE_IDLE;
                    o_nxt.len  = '0;
                end
                o_res = '{1'b1, KIND_BYTES, i_byte, 1'b1, (i_cur.len <= LEN_BITS'(1))};
            end
            MODE_ERROR: begin
                o_nxt = i_cur;
            end
            default: begin
                o_nxt.mode = MODE_ERROR;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/bencoded_token_stream_parser_unit.sv
// Bencode tokenizer, one byte per request: parser state plus output register.
// Depends on btsp_pkg and btsp_step.
//
// Usage:
//  - Input channel: i_in_valid / o_in_ready carry one raw byte (i_byte_in)
//    per request. Output channel: o_out_valid / i_out_ready carry one token
//    result (o_token_kind, o_data_byte, o_has_data, o_last) per request.
//  - Each byte yields zero or one result. Bytes that yield nothing (an 'i',
//    length digits, the ':' before a nonempty string) are simply absorbed.
//  - Result: a result is loaded into the output register at the edge that
//    accepts its byte.
//  - Throughput: one byte per clock unless stalled. The whole decision
//    (mode case plus the length shift-add and overflow test) is one
//    combinational pass between the state register and the output register.
//  - Stall: o_in_ready is high while the output register is empty or is
//    being drained this cycle, so a stalled receiver holds the pending
//    result and blocks the input until it is taken.
//  - After an Invalid result the parser sits in its error mode: bytes keep
//    being accepted and dropped until reset.
//  - Reset (i_rst_n low, synchronous): mode idle, counters zero, output
//    register empty. No clearing pass; ready again the cycle after reset.
`default_nettype none

module bencoded_token_stream_parser_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_byte_in,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [2:0]      o_token_kind,
    output logic [7:0]      o_data_byte,
    output logic            o_has_data,
    output logic            o_last
);
    import btsp_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_result step_res;

    logic       r_out_valid;
    logic [2:0] r_kind;
    logic [7:0] r_data;
    logic       r_has_data;
    logic       r_last;

    logic in_acc;

    btsp_step u_step (
        .i_byte (i_byte_in),
        .i_cur  (r_state),
        .o_nxt  (n_state),
        .o_res  (step_res)
    );

    // output register frees up in the same cycle it is drained
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '{MODE_IDLE, '0, '0, 1'b0};
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_state     <= n_state;
                r_out_valid <= step_res.valid;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload loads only when a new result is produced
    always_ff @(posedge i_clk) begin
        if (in_acc && step_res.valid) begin
            r_kind     <= step_res.kind;
            r_data     <= step_res.data;
            r_has_data <= step_res.has_data;
            r_last     <= step_res.last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_token_kind = r_kind;
    assign o_data_byte  = r_data;
    assign o_has_data   = r_has_data;
    assign o_last       = r_last;

endmodule

`default_nettype wire

>>> src/btsp_checker.sv
// Port-level checks for the bencode tokenizer, bound onto the top level.
// Depends on btsp_pkg and bencoded_token_stream_parser_unit_macros.svh.
`default_nettype none
`include "bencoded_token_stream_parser_unit_macros.svh"

module btsp_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [2:0] o_token_kind,
    input wire logic [7:0] o_data_byte,
    input wire logic       o_has_data,
    input wire logic       o_last
);
    import btsp_pkg::*;

    logic        out_stall;
    logic        out_invalid;
    logic        inv_taken;
    logic        data_kind_ok;
    logic [12:0] out_word;

    assign out_stall    = o_out_valid && !i_out_ready;
    assign out_invalid  = o_out_valid && (o_token_kind == KIND_INVALID);
    assign inv_taken    = out_invalid && i_out_ready;
    assign data_kind_ok = (o_token_kind == KIND_INT) || (o_token_kind == KIND_BYTES);
    assign out_word     = {o_token_kind, o_data_byte, o_has_data, o_last};

    // a stalled result holds
    `BTSP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(out_word))
    // Invalid is a single empty closing result
    `BTSP_ASSERT_NOW(a_invalid_shape, i_clk, i_rst_n, out_invalid, o_last && !o_has_data)
    // a taken Invalid leaves the output register empty after it
    `BTSP_ASSERT_NEXT(a_sticky_error, i_clk, i_rst_n, inv_taken, !o_out_valid)
    // data-less results carry a zero byte; data results never exceed string kind
    `BTSP_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, o_out_valid && !o_has_data, o_data_byte == 8'd0)
    `BTSP_ASSERT_NOW(a_data_kind, i_clk, i_rst_n, o_out_valid && o_has_data, data_kind_ok)

endmodule

bind bencoded_token_stream_parser_unit btsp_checker u_btsp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_token_kind (o_token_kind),
    .o_data_byte  (o_data_byte),
    .o_has_data   (o_has_data),
    .o_last       (o_last)
);

`default_nettype wire

>>> bench/tb_bencoded_token_stream_parser_unit.sv
// Testbench for the bencode tokenizer: byte requests in, token results out, each one
// checked against an in-bench tokenizer model. Depends on btsp_pkg and the
// bencoded_token_stream_parser_unit RTL.
module tb_bencoded_token_stream_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import btsp_pkg::*;

    // A full period with no request moving on either channel means the block is stuck.
    // Random gaps and stalls of 53% make so long a quiet run very unlikely.
    localparam int QUIET_LIMIT = 2000;

    // Largest string length that the length field can hold.
    localparam logic [63:0] LEN_MAX = (64'd1 << LEN_BITS) - 64'd1;

    // One token result, as it leaves the block.
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       has_data;
        logic       last;
    } t_token;

    // The fault that puts the block into its sticky error state at the end of the run.
    typedef enum int {
        FAULT_BAD_START,
        FAULT_INT_TOO_LONG,
        FAULT_LEN_TOO_LONG,
        FAULT_LEN_TOO_BIG
    } t_fault;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_byte_in   = 8'h00;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [2:0] o_token_kind;
    logic [7:0] o_data_byte;
    logic       o_has_data;
    logic       o_last;

    // Tokenizer model state. Reset is applied once, before any byte, so the
    // initial values are the reset values.
    logic [2:0]  parse_mode  = MODE_IDLE;
    int          field_count = 0;     // characters of integer text or length text
    logic [63:0] len_due     = '0;    // length value, then payload bytes still due
    logic        digits_done = 1'b0;  // set at the first non-digit of the length text

    t_token tokens_due[$];  // predicted token results, oldest first

    int bytes_taken   = 0;  // byte requests accepted by the block
    int bytes_sent    = 0;
    int tokens_seen   = 0;
    int invalid_seen  = 0;
    int n_errors      = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    t_fault fault_case = FAULT_BAD_START;

    bencoded_token_stream_parser_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_byte_in   (i_byte_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_token_kind(o_token_kind),
        .o_data_byte (o_data_byte),
        .o_has_data  (o_has_data),
        .o_last      (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: ready is redrawn every cycle at the falling edge.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // Tokenizer model
    // ------------------------------------------------------------------

    task automatic push_token(input logic [2:0] kind, input logic [7:0] data,
                              input logic has_data, input logic last);
        tokens_due.push_back('{kind: kind, data: data, has_data: has_data, last: last});
    endtask

    // Any fault: one Invalid result, then every later byte is dropped.
    task automatic raise_invalid();
        parse_mode = MODE_ERROR;
        push_token(KIND_INVALID, 8'h00, 1'b0, 1'b1);
    endtask

    // Counts one more field character; saturates just past the limit.
    function automatic bit field_too_long();
        if (field_count <= MAX_FIELD_CHARS)
            field_count++;
        return field_count > MAX_FIELD_CHARS;
    endfunction

    task automatic predict_byte(input logic [7:0] b);
        logic        is_digit;
        logic [63:0] digit_val;
        is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
        digit_val = 64'(b) - 64'(CH_ZERO);
        case (parse_mode)
            MODE_IDLE: begin
                if (b == CH_L) begin
                    push_token(KIND_LIST, 8'h00, 1'b0, 1'b1);
                end else if (b == CH_D) begin
                    push_token(KIND_DICT, 8'h00, 1'b0, 1'b1);
                end else if (b == CH_E) begin
                    push_token(KIND_END, 8'h00, 1'b0, 1'b1);
                end else if (b == CH_I) begin
                    parse_mode  = MODE_INT;
                    field_count = 0;
                end else if (is_digit) begin
                    // first length digit: one character, a value no field can overflow
                    parse_mode  = MODE_LEN;
                    field_count = 1;
                    len_due     = digit_val;
                    digits_done = 1'b0;
                end else begin
                    raise_invalid();
                end
            end
            MODE_INT: begin
                if (b == CH_E) begin
                    parse_mode = MODE_IDLE;
                    push_token(KIND_INT, 8'h00, 1'b0, 1'b1);
                end else if (field_too_long()) begin
                    raise_invalid();
                end else begin
                    push_token(KIND_INT, b, 1'b1, 1'b0);
                end
            end
            MODE_LEN: begin
                if (b == CH_COLON) begin
                    if (len_due == 0) begin
                        parse_mode = MODE_IDLE;
                        push_token(KIND_BYTES, 8'h00, 1'b0, 1'b1);
                    end else begin
                        parse_mode = MODE_PAYLOAD;
                    end
                end else if (field_too_long()) begin
                    raise_invalid();
                end else if (!digits_done) begin
                    if (!is_digit) begin
                        digits_done = 1'b1;
                    end else if (len_due > (LEN_MAX - digit_val) / 10) begin
                        raise_invalid();
                    end else begin
                        len_due = len_due * 10 + digit_val;
                    end
                end
            end
            MODE_PAYLOAD: begin
                if (len_due <= 1) begin
                    parse_mode = MODE_IDLE;
                    len_due    = '0;
                    push_token(KIND_BYTES, b, 1'b1, 1'b1);
                end else begin
                    len_due = len_due - 1;
                    push_token(KIND_BYTES, b, 1'b1, 1'b0);
                end
            end
            default: begin
                // error state: byte dropped, nothing due
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            n_errors++;
        end
    endtask

    task automatic check_token(input t_token got);
        t_token want;
        tokens_seen++;
        if (got.kind == KIND_INVALID)
            invalid_seen++;
        if (tokens_due.size() == 0) begin
            $error("token result with none due: kind %0d data 0x%02h has_data %0b last %0b",
                   got.kind, got.data, got.has_data, got.last);
            n_errors++;
            return;
        end
        want = tokens_due.pop_front();
        check_field("token_kind", want.kind, got.kind);
        check_field("data_byte", want.data, got.data);
        check_field("has_data", want.has_data, got.has_data);
        check_field("last", want.last, got.last);
    endtask

    // Both channels sampled at the rising edge. The result is checked before the
    // byte of the same edge is modeled; the block registers the result for a byte,
    // so it comes out only after that edge and this order is the order of the queue.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                check_token('{kind: o_token_kind, data: o_data_byte,
                              has_data: o_has_data, last: o_last});
            if (i_in_valid && o_in_ready) begin
                predict_byte(i_byte_in);
                bytes_taken <= bytes_taken + 1;
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Sends one byte request. Entered and left at a falling edge; valid stays high
    // on return so back-to-back bytes need no gap.
    task automatic send_byte(input logic [7:0] b);
        int taken_before;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_byte_in    <= b;
        taken_before = bytes_taken;
        @(negedge i_clk);
        while (bytes_taken == taken_before)
            @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        foreach (s[k])
            send_byte(s[k]);
    endtask

    // Holds the sender off until every predicted result has come out.
    task automatic wait_tokens_drained();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (tokens_due.size() != 0)
            @(negedge i_clk);
    endtask

    // 'i', n_chars of integer text (anything but 'e'), 'e'.
    task automatic send_int_token(input int n_chars);
        logic [7:0] b;
        send_byte(CH_I);
        repeat (n_chars) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_E);
            send_byte(b);
        end
        send_byte(CH_E);
    endtask

    // Length text (leading zeros, decimal length, ignored junk), ':', payload.
    // The zero count is trimmed so that the length text never exceeds the field limit.
    task automatic send_string_token(input int n_len, input int n_zeros, input int n_junk);
        string      len_text;
        logic [7:0] b;
        len_text = $sformatf("%0d", n_len);
        if (n_zeros + len_text.len() + n_junk > MAX_FIELD_CHARS)
            n_zeros = MAX_FIELD_CHARS - len_text.len() - n_junk;
        repeat (n_zeros)
            send_byte(CH_ZERO);
        send_text(len_text);
        for (int k = 0; k < n_junk; k++) begin
            // first junk byte ends the digits; later ones may be digits and are ignored
            do b = 8'($urandom_range(0, 255));
            while (b == CH_COLON || (k == 0 && b >= CH_ZERO && b <= CH_NINE));
            send_byte(b);
        end
        send_byte(CH_COLON);
        repeat (n_len)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // One well-formed token with random content; always returns the block to idle.
    task automatic send_random_token();
        int pick;
        int n_len;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            send_byte(CH_L);
        end else if (pick == 1) begin
            send_byte(CH_D);
        end else if (pick == 2) begin
            send_byte(CH_E);
        end else if (pick <= 5) begin
            send_int_token(($urandom_range(0, 15) == 0) ? $urandom_range(0, MAX_FIELD_CHARS)
                                                        : $urandom_range(0, 6));
        end else begin
            n_len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 300)
                                                 : $urandom_range(0, 16);
            // zero count of 99 fills the length text right up to the limit
            send_string_token(n_len,
                              ($urandom_range(0, 15) == 0) ? 99 :
                              ($urandom_range(0, 3) == 0)  ? $urandom_range(1, 3) : 0,
                              ($urandom_range(0, 4) == 0)  ? $urandom_range(1, 6) : 0);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Each token kind but Invalid, data extremes, empty integer, empty string,
    // junk inside the length text.
    task automatic test_directed_tokens();
        send_text("lde");
        send_text("ie");
        send_byte(CH_I);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_E);
        send_text("0:");
        send_text("2:");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("1x5:A");  // length 1: the '5' after the junk is ignored
        wait_tokens_drained();
    endtask

    // Integer text and length text exactly at the field limit.
    task automatic test_field_limits();
        send_int_token(MAX_FIELD_CHARS);
        send_string_token(5, 99, 0);
        send_string_token(3, 99, 2);
        wait_tokens_drained();
    endtask

    // Random well-formed token stream under one idling pattern, then a full drain.
    task automatic test_random_stream(input int n_bytes, input int idle_pct,
                                      input int ready_stall_pct);
        int start_count;
        send_idle_pct = idle_pct;
        stall_pct     = ready_stall_pct;
        start_count   = bytes_sent;
        while (bytes_sent - start_count < n_bytes)
            send_random_token();
        wait_tokens_drained();
    endtask

    // The error state is sticky and reset comes only once, so exactly one fault
    // kind is driven per run; the seed picks which. Bytes after it must vanish.
    task automatic test_sticky_error();
        logic [7:0] b;
        fault_case = t_fault'($urandom_range(0, 3));
        case (fault_case)
            FAULT_BAD_START: begin
                do b = 8'($urandom_range(0, 255));
                while (b == CH_L || b == CH_D || b == CH_E || b == CH_I ||
                       (b >= CH_ZERO && b <= CH_NINE));
                send_byte(b);
            end
            FAULT_INT_TOO_LONG: begin
                send_int_token(MAX_FIELD_CHARS + 1);
            end
            FAULT_LEN_TOO_LONG: begin
                // largest legal length value, then junk until the field overflows
                send_text("4294967295");
                send_byte(CH_COLON + 8'd1);
                repeat (MAX_FIELD_CHARS - 10)
                    send_byte(CH_E);
            end
            default: begin
                send_text("4294967296");
            end
        endcase
        repeat (24)
            send_byte(8'($urandom_range(0, 255)));
        wait_tokens_drained();
    endtask

    initial begin
        // synchronous reset held low at the start, released at a falling edge
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_tokens();
        test_field_limits();
        test_random_stream(210, 0, 0);
        test_random_stream(210, 53, 0);
        test_random_stream(210, 0, 53);
        test_random_stream(210, 20, 20);
        test_sticky_error();

        // the result is registered; idle time at the end catches any stray result
        repeat (8) @(negedge i_clk);

        $display("Covered %0d byte requests and %0d token results (%0d invalid),",
                 bytes_sent, tokens_seen, invalid_seen);
        $display("under four idle/stall patterns, ending with fault %s.", fault_case.name());
        if (n_errors == 0 && tokens_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/btsp_pkg.sv
src/btsp_step.sv
src/bencoded_token_stream_parser_unit.sv
src/btsp_checker.sv
bench/tb_bencoded_token_stream_parser_unit.sv
